/* design/brme_pkg.sv */
// Shared types and constants for the blocked running mean and error block.
// No dependencies; imported by brme_unit, brme_core and the top level.
package brme_pkg;

  localparam int SAMPLE_W = 32;
  localparam int LEN_W    = 16;
  localparam int NBLK_W   = 11;
  localparam int INDEX_W  = 10;
  localparam int BSUM_W   = 48;
  localparam int SOA_W    = 43;
  localparam int SOS_W    = 58;
  localparam int OPND_W   = 64;
  localparam int REM_W    = 36;
  localparam int STEP_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Block count limit, also bounded by the width of block_index.
  localparam logic [NBLK_W-1:0] MAX_BLOCKS = 11'd1024;

  localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RESET = 16'd1000;
  localparam logic [NBLK_W-1:0] NUM_BLOCKS_RESET   = 11'd100;

  localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd64;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd32;

  // Largest variance passed on to the final division.
  localparam logic [46:0] VAR_MAX = {47{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS   = 2'd1;

  typedef enum logic [1:0] {
    OP_DIV  = 2'b01,
    OP_SQRT = 2'b10
  } unit_op_t;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_LOAD  = 13'b0000000000010,
    ST_AVG   = 13'b0000000000100,
    ST_MULA  = 13'b0000000001000,
    ST_ACC   = 13'b0000000010000,
    ST_MEAN  = 13'b0000000100000,
    ST_MULM  = 13'b0000001000000,
    ST_MSQ   = 13'b0000010000000,
    ST_VDIV  = 13'b0000100000000,
    ST_VWAIT = 13'b0001000000000,
    ST_SQRT  = 13'b0010000000000,
    ST_SWAIT = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic [INDEX_W-1:0]         block_index;
    logic signed [SAMPLE_W-1:0] running_mean;
    logic [SAMPLE_W-1:0]        running_error;
    logic                       final_block;
  } result_t;

endpackage

/* design/brme_unit.sv */
// Shared iterative unit: restoring division (one quotient bit per cycle) and
// integer square root (one root bit per cycle). Depends on brme_pkg.
module brme_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  brme_pkg::unit_op_t      op,
  input  logic [brme_pkg::OPND_W-1:0] operand,
  input  logic [brme_pkg::LEN_W-1:0]  divisor,
  output logic                    done,
  output logic [brme_pkg::OPND_W-1:0] result
);
  import brme_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] steps;
  unit_op_t          op_r;
  logic [LEN_W-1:0]  dvsr;
  logic [OPND_W-1:0] src;
  logic [REM_W-1:0]  rem;
  logic [OPND_W-1:0] quo;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] trial;
  logic [REM_W:0]   diff;
  logic             fits;

  // A square root step brings in two radicand bits and tries 4*root + 1; a
  // division step brings in one dividend bit and tries the divisor.
  always_comb begin
    if (op_r == OP_SQRT) begin
      shifted = {rem[REM_W-3:0], src[OPND_W-1 -: 2]};
      trial   = {quo[REM_W-3:0], 2'b01};
    end else begin
      shifted = {rem[REM_W-2:0], src[OPND_W-1]};
      trial   = {{(REM_W-LEN_W){1'b0}}, dvsr};
    end
    diff = {1'b0, shifted} - {1'b0, trial};
    fits = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= (op == OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= op;
      dvsr <= divisor;
      src  <= operand;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      src <= (op_r == OP_SQRT) ? {src[OPND_W-3:0], 2'b00} : {src[OPND_W-2:0], 1'b0};
      rem <= fits ? diff[REM_W-1:0] : shifted;
      quo <= {quo[OPND_W-2:0], fits};
    end
  end

  assign result = quo;

endmodule

/* design/brme_core.sv */
// Accumulators and sequencer: block sums, running sums, the squaring
// multiplier and the steps run on the shared unit. Depends on brme_pkg, brme_unit.
module brme_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [brme_pkg::SAMPLE_W-1:0] sample,
  input  logic [brme_pkg::LEN_W-1:0]    block_length,
  input  logic [brme_pkg::NBLK_W-1:0]   num_blocks,
  output logic                          ready,
  output logic                          res_valid,
  input  logic                          res_take,
  output brme_pkg::result_t             res
);
  import brme_pkg::*;

  state_t state;

  logic [LEN_W-1:0]        sample_count;
  logic signed [BSUM_W-1:0] block_sum;
  logic [NBLK_W-1:0]       blocks_done;
  logic signed [SOA_W-1:0] sum_of_averages;
  logic [SOS_W-1:0]        sum_of_squares;

  logic [SAMPLE_W-1:0]     avg_mag;
  logic                    avg_neg;
  logic [SAMPLE_W-1:0]     mean_mag;
  logic [2*SAMPLE_W-1:0]   prod;
  logic [SOS_W-1:0]        variance;

  logic                    unit_start;
  unit_op_t                unit_op;
  logic [OPND_W-1:0]       unit_operand;
  logic [LEN_W-1:0]        unit_divisor;
  logic                    unit_done;
  logic [OPND_W-1:0]       unit_result;

  logic [LEN_W-1:0]        len_eff;
  logic [NBLK_W-1:0]       limit;
  logic [LEN_W-1:0]        count_inc;
  logic [BSUM_W-1:0]       bsum_mag;
  logic [SOA_W-1:0]        soa_mag;
  logic [SOS_W:0]          var_diff;
  logic [46:0]             var_clamped;

  assign len_eff   = (block_length == '0) ? 16'd1 : block_length;
  assign limit     = (num_blocks > MAX_BLOCKS) ? MAX_BLOCKS : num_blocks;
  assign count_inc = sample_count + 16'd1;
  assign bsum_mag  = block_sum[BSUM_W-1] ? BSUM_W'(-block_sum) : block_sum;
  assign soa_mag   = sum_of_averages[SOA_W-1] ? SOA_W'(-sum_of_averages) : sum_of_averages;
  assign var_diff  = {1'b0, unit_result[SOS_W-1:0]} - {11'b0, prod[2*SAMPLE_W-1:16]};
  assign var_clamped = (variance[SOS_W-1:47] != '0) ? VAR_MAX : variance[46:0];

  always_comb begin
    unit_start   = 1'b0;
    unit_op      = OP_DIV;
    unit_operand = '0;
    unit_divisor = '0;
    unique case (state)
      ST_LOAD: begin
        unit_start   = 1'b1;
        unit_operand = {{(OPND_W-BSUM_W){1'b0}}, bsum_mag};
        unit_divisor = len_eff;
      end
      ST_ACC: begin
        unit_start   = 1'b1;
        unit_operand = {{(OPND_W-SOA_W){1'b0}}, soa_mag};
        unit_divisor = {{(LEN_W-NBLK_W){1'b0}}, blocks_done};
      end
      ST_MULM: begin
        unit_start   = 1'b1;
        unit_operand = {{(OPND_W-SOS_W){1'b0}}, sum_of_squares};
        unit_divisor = {{(LEN_W-NBLK_W){1'b0}}, blocks_done};
      end
      ST_VDIV: begin
        unit_start   = 1'b1;
        unit_operand = {1'b0, var_clamped, 16'b0};
        unit_divisor = {{(LEN_W-NBLK_W){1'b0}}, NBLK_W'(blocks_done - 1'b1)};
      end
      ST_SQRT: begin
        unit_start   = 1'b1;
        unit_op      = OP_SQRT;
        unit_operand = unit_result;
      end
      default: begin
        unit_start = 1'b0;
      end
    endcase
  end

  brme_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .op      (unit_op),
    .operand (unit_operand),
    .divisor (unit_divisor),
    .done    (unit_done),
    .result  (unit_result)
  );

  // Control state and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      sample_count    <= '0;
      block_sum       <= '0;
      blocks_done     <= '0;
      sum_of_averages <= '0;
      sum_of_squares  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // Samples beyond the block limit are taken and dropped.
          if (accept && (blocks_done < limit)) begin
            block_sum    <= block_sum + BSUM_W'(sample);
            sample_count <= count_inc;
            if (count_inc >= len_eff) begin
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          block_sum    <= '0;
          sample_count <= '0;
          state        <= ST_AVG;
        end
        ST_AVG: begin
          if (unit_done) begin
            state <= ST_MULA;
          end
        end
        ST_MULA: begin
          sum_of_averages <= avg_neg ? sum_of_averages - SOA_W'(avg_mag)
                                     : sum_of_averages + SOA_W'(avg_mag);
          blocks_done     <= blocks_done + 1'b1;
          state           <= ST_ACC;
        end
        ST_ACC: begin
          sum_of_squares <= sum_of_squares + SOS_W'(prod[2*SAMPLE_W-1:16]);
          state          <= ST_MEAN;
        end
        ST_MEAN: begin
          if (unit_done) begin
            state <= (blocks_done == 11'd1) ? ST_DONE : ST_MULM;
          end
        end
        ST_MULM:  state <= ST_MSQ;
        ST_MSQ: begin
          if (unit_done) begin
            state <= ST_VDIV;
          end
        end
        ST_VDIV:  state <= ST_VWAIT;
        ST_VWAIT: begin
          if (unit_done) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT:  state <= ST_SWAIT;
        ST_SWAIT: begin
          if (unit_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Working values and the result; these need no reset.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      avg_neg <= block_sum[BSUM_W-1];
    end
    if ((state == ST_AVG) && unit_done) begin
      avg_mag <= unit_result[SAMPLE_W-1:0];
    end
    if (state == ST_MULA) begin
      prod <= avg_mag * avg_mag;
    end
    if (state == ST_ACC) begin
      res.block_index   <= INDEX_W'(blocks_done - 1'b1);
      res.final_block   <= (blocks_done == limit);
      res.running_error <= '0;
      res.running_mean[SAMPLE_W-1] <= sum_of_averages[SOA_W-1];
    end
    if ((state == ST_MEAN) && unit_done) begin
      mean_mag <= unit_result[SAMPLE_W-1:0];
      // The sign was parked in the top bit of running_mean in ST_ACC.
      res.running_mean <= res.running_mean[SAMPLE_W-1] ? -unit_result[SAMPLE_W-1:0]
                                                       : unit_result[SAMPLE_W-1:0];
    end
    if (state == ST_MULM) begin
      prod <= mean_mag * mean_mag;
    end
    if ((state == ST_MSQ) && unit_done) begin
      variance <= var_diff[SOS_W] ? '0 : var_diff[SOS_W-1:0];
    end
    if ((state == ST_SWAIT) && unit_done) begin
      res.running_error <= unit_result[SAMPLE_W-1:0];
    end
  end

  assign ready     = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

endmodule

/* design/blocked_running_mean_error.sv */
// Top level of the blocked running mean and standard error estimator:
// configuration registers, handshakes and the output register.
// Depends on brme_pkg and brme_core.
//
// Usage: each input transaction carries one signed Q16.16 sample. Samples
// are summed into blocks of block_length; when a block completes, one output
// transaction gives the block index, the running mean of the block averages
// and the standard error of that mean, with final_block set on the last
// configured block. Samples after num_blocks blocks (at most 1024) are taken and dropped.
// A sample that does not complete a block is taken and the next can follow
// straight away. A sample that completes a block holds in_stall high while
// the shared divide/square-root unit works through four 64-step divisions
// and a 32-step square root (only two divisions for the first block), and
// until the output register takes the result. The unit works out one result
// bit per cycle.
// The output register keeps a result while out_stall is high; a later block
// that finishes meanwhile waits in the core until the register is free.
// Reset (rst, synchronous) clears all sums and counts and sets block_length
// to 1000 and num_blocks to 100. Configuration is accepted on every cycle
// and must be written only while the block is idle.
module blocked_running_mean_error (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [brme_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [brme_pkg::INDEX_W-1:0]          block_index,
  output logic signed [brme_pkg::SAMPLE_W-1:0]  running_mean,
  output logic [brme_pkg::SAMPLE_W-1:0]         running_error,
  output logic                                  final_block,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [brme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [brme_pkg::LEN_W-1:0]            cfg_data
);
  import brme_pkg::*;

  logic [LEN_W-1:0]  block_length;
  logic [NBLK_W-1:0] num_blocks;
  logic              core_ready;
  logic              res_valid;
  logic              res_take;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LENGTH_RESET;
      num_blocks   <= NUM_BLOCKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BLOCK_LENGTH) begin
        block_length <= cfg_data;
      end else if (cfg_index == CFG_NUM_BLOCKS) begin
        num_blocks <= cfg_data[NBLK_W-1:0];
      end
    end
  end

  assign in_stall = ~core_ready;

  brme_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_valid && core_ready),
    .sample       (sample),
    .block_length (block_length),
    .num_blocks   (num_blocks),
    .ready        (core_ready),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  // The output register is loaded whenever it is empty or being emptied.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      block_index   <= res.block_index;
      running_mean  <= res.running_mean;
      running_error <= res.running_error;
      final_block   <= res.final_block;
    end
  end

  // A result never waits in the core while it is ready for samples.
  assert property (@(posedge clk) disable iff (rst) core_ready |-> !res_valid)
    else $error("core accepts samples while a result is pending");

  // The first block has no spread, so its error is zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (block_index == '0)) |-> (running_error == '0))
    else $error("non-zero error reported for the first block");

  // A result taken into the output register is shown in the next cycle.
  assert property (@(posedge clk) disable iff (rst) res_take |=> out_valid)
    else $error("output register lost a result");

endmodule

/* test/tb_blocked_running_mean_error.sv */
// Testbench for blocked_running_mean_error: named tests drive samples and register
// writes, and an internal predictor checks every block result field by field.
// Depends on brme_pkg and the RTL of blocked_running_mean_error only.
module tb_blocked_running_mean_error;
  import brme_pkg::*;

  // The register map leaves these two indexes unused; writes to them change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_BLOCK_CAP = 900;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [INDEX_W-1:0]         block_index;
  logic signed [SAMPLE_W-1:0] running_mean;
  logic [SAMPLE_W-1:0]        running_error;
  logic                       final_block;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [LEN_W-1:0]           cfg_data = '0;

  // Predictor copy of the registers and the accumulated sums.
  int unsigned len_reg = BLOCK_LENGTH_RESET;
  int unsigned nblk_reg = NUM_BLOCKS_RESET;
  int unsigned blk_count = 0;
  int unsigned blocks_done = 0;
  int unsigned samples_used = 0;
  longint      blk_sum = 0;
  longint      avg_sum = 0;
  bit [63:0]   sq_sum = '0;

  result_t awaited_estimates[$];
  int      in_gap_pct = 0;
  int      out_gap_pct = 0;
  int      error_count = 0;

  blocked_running_mean_error i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .block_index   (block_index),
    .running_mean  (running_mean),
    .running_error (running_error),
    .final_block   (final_block),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic bit [63:0] q16_square(input longint v);
    bit [63:0] mag;
    mag = (v < 0) ? -v : v;
    return (mag * mag) >> 16;
  endfunction

  function automatic bit [63:0] floor_sqrt(input bit [63:0] x);
    bit [63:0] root;
    bit [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Adds one accepted sample to the model and queues the block result it completes.
  task automatic update_estimate(input logic signed [SAMPLE_W-1:0] s);
    int unsigned lim;
    int unsigned len_eff;
    longint      avg;
    longint      mean;
    bit [63:0]   k;
    bit [63:0]   msq;
    bit [63:0]   m2;
    bit [63:0]   spread;
    bit [63:0]   err;
    result_t     r;
    lim = nblk_reg;
    if (lim > MAX_BLOCKS) lim = MAX_BLOCKS;
    if (lim > (1 << INDEX_W)) lim = 1 << INDEX_W;
    len_eff = (len_reg == 0) ? 1 : len_reg;
    if (blocks_done >= lim) return;
    samples_used++;
    blk_sum += longint'(s);
    blk_count++;
    if (blk_count < len_eff) return;

    avg = blk_sum / longint'(len_eff);
    blk_sum = 0;
    blk_count = 0;
    avg_sum += avg;
    sq_sum += q16_square(avg);
    blocks_done++;
    k = blocks_done;
    mean = avg_sum / longint'(blocks_done);
    err = '0;
    if (k > 1) begin
      msq = sq_sum / k;
      m2 = q16_square(mean);
      // Truncation can leave the mean of squares below the squared mean.
      spread = (msq > m2) ? msq - m2 : '0;
      if (spread > VAR_MAX) spread = VAR_MAX;
      err = floor_sqrt((spread << 16) / (k - 1));
      if (err > 64'hFFFF_FFFF) err = 64'hFFFF_FFFF;
    end
    r.block_index = INDEX_W'(blocks_done - 1);
    r.running_mean = mean[SAMPLE_W-1:0];
    r.running_error = err[SAMPLE_W-1:0];
    r.final_block = (blocks_done == lim);
    awaited_estimates.push_back(r);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (in_stall);
    update_estimate(value);
  endtask

  // Leaves cfg_valid high so that back-to-back writes follow straight on.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BLOCK_LENGTH: len_reg = data;
      CFG_NUM_BLOCKS:   nblk_reg = data[NBLK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_config;
    cfg_valid <= 1'b0;
  endtask

  // Waits for every awaited result and then for the block's longest busy stretch.
  task automatic settle;
    in_valid <= 1'b0;
    while (awaited_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] bounded_sample;
    return $signed($urandom) >>> 3;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample(
    input logic signed [SAMPLE_W-1:0] centre
  );
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = SAMPLE_MAX;
          1: v = SAMPLE_MIN;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1, 2: v = $signed($urandom_range(2047)) - 1024;
      3, 4, 5, 6: v = centre + $signed($urandom_range(65535)) - 32768;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < out_gap_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_estimates.size() == 0) begin
        report_error($sformatf("result for block %0d with none awaited", block_index));
      end else begin
        want = awaited_estimates.pop_front();
        if (block_index !== want.block_index)
          report_error($sformatf("block_index got %0d expected %0d",
                                 block_index, want.block_index));
        if (running_mean !== want.running_mean)
          report_error($sformatf("block %0d running_mean got %h expected %h",
                                 want.block_index, running_mean, want.running_mean));
        if (running_error !== want.running_error)
          report_error($sformatf("block %0d running_error got %h expected %h",
                                 want.block_index, running_error, want.running_error));
        if (final_block !== want.final_block)
          report_error($sformatf("block %0d final_block got %b expected %b",
                                 want.block_index, final_block, want.final_block));
      end
    end
  end

  // The first block must give zero error; the second has a variance that
  // truncation pushes below zero, which must be clamped.
  task automatic test_negative_variance;
    write_reg(CFG_BLOCK_LENGTH, 16'd1);
    write_reg(CFG_NUM_BLOCKS, LEN_W'(MAX_BLOCKS));
    close_config;
    send_sample(32'sd255);
    send_sample(32'sd257);
    settle;
  endtask

  // Lowering the block length part way through a block completes it on the next
  // sample; a length of zero behaves as one.
  task automatic test_length_change;
    write_reg(CFG_BLOCK_LENGTH, 16'd10);
    close_config;
    repeat (3) send_sample(bounded_sample());
    settle;
    write_reg(CFG_BLOCK_LENGTH, 16'd2);
    close_config;
    send_sample(bounded_sample());
    settle;
    write_reg(CFG_BLOCK_LENGTH, 16'hFFFF);
    close_config;
    repeat (2) send_sample(bounded_sample());
    settle;
    write_reg(CFG_BLOCK_LENGTH, 16'd0);
    close_config;
    send_sample(bounded_sample());
    settle;
  endtask

  task automatic test_extreme_samples;
    write_reg(CFG_BLOCK_LENGTH, 16'd1);
    close_config;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    settle;
    write_reg(CFG_BLOCK_LENGTH, 16'd2);
    close_config;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    settle;
  endtask

  // Samples beyond the block limit are dropped; the upper bits of a num_blocks
  // write are discarded, so the last write here sets a limit of zero.
  task automatic test_block_limit;
    write_reg(CFG_BLOCK_LENGTH, 16'd1);
    write_reg(CFG_NUM_BLOCKS, LEN_W'(blocks_done + 2));
    write_reg(CFG_SPARE_2, LEN_W'($urandom));
    write_reg(CFG_SPARE_3, LEN_W'($urandom));
    close_config;
    repeat (4) send_sample(random_sample('0));
    settle;
    write_reg(CFG_NUM_BLOCKS, 16'hF800);
    close_config;
    repeat (2) send_sample(random_sample('0));
    settle;
  endtask

  // Each segment sends whole blocks only, so a later length change never
  // meets a part-filled block.
  task automatic test_random_blocks(input int unsigned target);
    int unsigned start;
    int unsigned len;
    int unsigned n;
    logic signed [SAMPLE_W-1:0] centre;
    start = samples_used;
    while (samples_used - start < target && blocks_done < RANDOM_BLOCK_CAP) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      n = (len > 8) ? len : len * $urandom_range(1, 6);
      write_reg(CFG_BLOCK_LENGTH, LEN_W'(len));
      if ($urandom_range(1) == 0)
        write_reg(CFG_NUM_BLOCKS, LEN_W'(RANDOM_BLOCK_CAP));
      else
        write_reg(CFG_NUM_BLOCKS, LEN_W'(blocks_done + $urandom_range(2, 12)));
      close_config;
      centre = $signed($urandom) >>> 2;
      repeat (n) send_sample(random_sample(centre));
      settle;
    end
  endtask

  // Runs up to the absolute block limit so that the last block index and the
  // final_block flag appear, then checks that later samples are dropped.
  task automatic test_final_block;
    logic signed [SAMPLE_W-1:0] centre;
    write_reg(CFG_BLOCK_LENGTH, 16'd1);
    write_reg(CFG_NUM_BLOCKS, 16'd2047);
    close_config;
    centre = $signed($urandom) >>> 2;
    while (blocks_done < MAX_BLOCKS) send_sample(random_sample(centre));
    repeat (6) send_sample(random_sample(centre));
  endtask

  initial begin
    in_gap_pct = 18;
    out_gap_pct = 85;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_negative_variance;
    test_length_change;
    test_extreme_samples;
    test_block_limit;
    test_random_blocks(160);
    in_gap_pct = 85;
    out_gap_pct = 18;
    test_random_blocks(160);
    in_gap_pct = 0;
    out_gap_pct = 0;
    test_final_block;
    settle;
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
